// ===== sv/assert_macros.svh =====
// Assertion macros used by the checks in the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define TWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define TWC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/twc_pkg.sv =====
// Package with wrap mode codes, register indexes and the pipeline flag bundle.
`default_nettype none

package twc_pkg;

  // Wrap mode codes; codes above MODE_MIRROR behave as black.
  typedef enum logic [2:0] {
    MODE_BLACK    = 3'd0,
    MODE_CLAMP    = 3'd1,
    MODE_PERIODIC = 3'd2,
    MODE_POW2     = 3'd3,
    MODE_MIRROR   = 3'd4
  } mode_t;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WRAP_MODE     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_ORIGIN = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_WIDTH  = 2'd2;

  // Flags that travel with each beat through the pipeline.
  typedef struct packed {
    logic neg;  // offset to origin was negative
    logic ok;   // final in_range value
  } twc_flags_t;

endpackage

`default_nettype wire

// ===== sv/twc_if.sv =====
// Valid/ready channel interfaces for coordinate input and wrapped result.
`default_nettype none

interface twc_in_if #(parameter int COORD_BITS = 24);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] coord_in;

  modport source (output valid, output coord_in, input ready);
  modport sink   (input valid, input coord_in, output ready);
endinterface

interface twc_out_if #(parameter int COORD_BITS = 24);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] coord_out;
  logic                  in_range;

  modport source (output valid, output coord_out, output in_range, input ready);
  modport sink   (input valid, input coord_out, input in_range, output ready);
endinterface

`default_nettype wire

// ===== sv/twc_pre.sv =====
// Front end: offset to origin, fold for the divider, simple mode results.
`default_nettype none

module twc_pre import twc_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  valid_i,
  input  logic [COORD_BITS-1:0] coord_i,
  input  logic [2:0]            mode,
  input  logic [COORD_BITS-1:0] org,
  input  logic [COORD_BITS-2:0] w,
  output logic                  valid_o,
  output logic [COORD_BITS-1:0] dvd_o,
  output logic [COORD_BITS-1:0] res_o,
  output twc_flags_t            flags_o
);

  logic                  v1_r;
  logic [COORD_BITS-1:0] c1_r;
  logic [COORD_BITS:0]   d1_r;
  logic [COORD_BITS:0]   d1_nxt;

  logic                  neg;
  logic                  in_win;
  logic [COORD_BITS-2:0] mask;
  logic [COORD_BITS-2:0] pow_off;
  logic [COORD_BITS-1:0] pow_res;
  logic [COORD_BITS-1:0] clamp_res;
  logic [COORD_BITS-1:0] dvd_nxt;
  logic [COORD_BITS-1:0] res_nxt;
  twc_flags_t            flags_nxt;

  logic                  v2_r;
  logic [COORD_BITS-1:0] dvd_r;
  logic [COORD_BITS-1:0] res_r;
  twc_flags_t            flags_r;

  // Form the offset one bit wider so it cannot overflow.
  assign d1_nxt = {coord_i[COORD_BITS-1], coord_i} - {org[COORD_BITS-1], org};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r <= coord_i;
      d1_r <= d1_nxt;
    end
  end

  // Fold negatives to -d-1, check the window, build clamp and mask results.
  always_comb begin
    neg       = d1_r[COORD_BITS];
    in_win    = !neg && (d1_r < {2'b00, w});
    dvd_nxt   = neg ? ~d1_r[COORD_BITS-1:0] : d1_r[COORD_BITS-1:0];
    mask      = w - 1'b1;
    pow_off   = d1_r[COORD_BITS-2:0] & mask;
    pow_res   = org + {1'b0, pow_off};
    if (neg) begin
      clamp_res = org;
    end else if (in_win) begin
      clamp_res = c1_r;
    end else begin
      clamp_res = org + {1'b0, mask};
    end
    flags_nxt.neg = neg;
    case (mode)
      MODE_CLAMP: begin
        res_nxt      = clamp_res;
        flags_nxt.ok = 1'b1;
      end
      MODE_PERIODIC, MODE_MIRROR: begin
        res_nxt      = c1_r;
        flags_nxt.ok = 1'b1;
      end
      MODE_POW2: begin
        res_nxt      = pow_res;
        flags_nxt.ok = 1'b1;
      end
      default: begin
        res_nxt      = c1_r;
        flags_nxt.ok = in_win;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvd_r   <= dvd_nxt;
      res_r   <= res_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign valid_o = v2_r;
  assign dvd_o   = dvd_r;
  assign res_o   = res_r;
  assign flags_o = flags_r;

endmodule

`default_nettype wire

// ===== sv/twc_div_stage.sv =====
// One restoring division step: shift in a dividend bit, subtract width if it fits.
`default_nettype none

module twc_div_stage import twc_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic [COORD_BITS-2:0] w,
  input  logic                  valid_i,
  input  logic [COORD_BITS-2:0] rem_i,
  input  logic [COORD_BITS-1:0] dvd_i,
  input  logic [COORD_BITS-1:0] res_i,
  input  twc_flags_t            flags_i,
  output logic                  valid_o,
  output logic [COORD_BITS-2:0] rem_o,
  output logic [COORD_BITS-1:0] dvd_o,
  output logic                  q_o,
  output logic [COORD_BITS-1:0] res_o,
  output twc_flags_t            flags_o
);

  logic [COORD_BITS-1:0] trial;
  logic [COORD_BITS-1:0] diff;
  logic                  ge;
  logic [COORD_BITS-2:0] rem_nxt;

  logic                  valid_r;
  logic [COORD_BITS-2:0] rem_r;
  logic [COORD_BITS-1:0] dvd_r;
  logic                  q_r;
  logic [COORD_BITS-1:0] res_r;
  twc_flags_t            flags_r;

  // Partial remainder stays below width, so it fits one bit less.
  always_comb begin
    trial   = {rem_i, dvd_i[COORD_BITS-1]};
    diff    = trial - {1'b0, w};
    ge      = trial >= {1'b0, w};
    rem_nxt = ge ? diff[COORD_BITS-2:0] : trial[COORD_BITS-2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r   <= rem_nxt;
      dvd_r   <= {dvd_i[COORD_BITS-2:0], 1'b0};
      q_r     <= ge;
      res_r   <= res_i;
      flags_r <= flags_i;
    end
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign dvd_o   = dvd_r;
  assign q_o     = q_r;
  assign res_o   = res_r;
  assign flags_o = flags_r;

endmodule

`default_nettype wire

// ===== sv/twc_post.sv =====
// Back end: reflect the remainder where needed and add the origin back.
`default_nettype none

module twc_post import twc_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic [2:0]            mode,
  input  logic [COORD_BITS-1:0] org,
  input  logic [COORD_BITS-2:0] w,
  input  logic                  valid_i,
  input  logic [COORD_BITS-2:0] rem_i,
  input  logic                  q_i,
  input  logic [COORD_BITS-1:0] res_i,
  input  twc_flags_t            flags_i,
  output logic                  valid_o,
  output logic [COORD_BITS-1:0] coord_o,
  output logic                  in_range_o
);

  logic                  flip;
  logic                  use_div;
  logic [COORD_BITS-2:0] r_nxt;

  logic                  valid_r;
  logic [COORD_BITS-2:0] r_r;
  logic                  use_div_r;
  logic [COORD_BITS-1:0] res_r;
  logic                  ok_r;

  // Periodic flips negative offsets; mirror flips odd periods.
  always_comb begin
    flip    = (mode == MODE_PERIODIC) ? flags_i.neg : q_i;
    use_div = mode inside {MODE_PERIODIC, MODE_MIRROR};
    r_nxt   = flip ? (w - 1'b1 - rem_i) : rem_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r       <= r_nxt;
      use_div_r <= use_div;
      res_r     <= res_i;
      ok_r      <= flags_i.ok;
    end
  end

  // Divide modes add origin back; the sum wraps to the coordinate width.
  assign coord_o    = use_div_r ? (org + {1'b0, r_r}) : res_r;
  assign valid_o    = valid_r;
  assign in_range_o = ok_r;

endmodule

`default_nettype wire

// ===== sv/texture_coordinate_wrap.sv =====
// Texture coordinate wrap: maps a signed coordinate into a window by wrap mode.
// One division step per stage sets the pipeline depth.
// Throughput: one beat per cycle while the skid stage is empty.
// A two-entry output register and skid stage keep input flowing while a result waits.
// Reset (rst_n, synchronous): pipeline empties, mode black, origin 0, width 1.
`default_nettype none
`include "assert_macros.svh"

module texture_coordinate_wrap import twc_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  twc_in_if.sink                  in_s,
  twc_out_if.source               out_m,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]   cfg_data
);

  logic [2:0]            wrap_mode_r;
  logic [COORD_BITS-1:0] origin_r;
  logic [COORD_BITS-2:0] width_r;
  logic [COORD_BITS-2:0] w_eff;
  logic                  en;

  logic                  dv_valid [0:COORD_BITS];
  logic [COORD_BITS-2:0] dv_rem   [0:COORD_BITS];
  logic [COORD_BITS-1:0] dv_dvd   [0:COORD_BITS];
  logic [COORD_BITS-1:0] dv_res   [0:COORD_BITS];
  twc_flags_t            dv_flags [0:COORD_BITS];
  logic                  dv_q     [1:COORD_BITS];

  logic                  post_valid;
  logic [COORD_BITS-1:0] post_coord;
  logic                  post_ok;

  logic                  out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0] out_coord_r, out_coord_nxt;
  logic                  out_ok_r, out_ok_nxt;
  logic                  skid_valid_r, skid_valid_nxt;
  logic [COORD_BITS-1:0] skid_coord_r, skid_coord_nxt;
  logic                  skid_ok_r, skid_ok_nxt;
  logic                  take;
  logic                  incoming;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_mode_r <= MODE_BLACK;
      origin_r    <= '0;
      width_r     <= {{(COORD_BITS-2){1'b0}}, 1'b1};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WRAP_MODE:     wrap_mode_r <= cfg_data[2:0];
        CFG_WINDOW_ORIGIN: origin_r    <= cfg_data;
        CFG_WINDOW_WIDTH:  width_r     <= cfg_data[COORD_BITS-2:0];
        default:           ;
      endcase
    end
  end

  // Treat a zero width as one.
  assign w_eff = (width_r == '0) ? {{(COORD_BITS-2){1'b0}}, 1'b1} : width_r;

  // Advance the whole pipeline unless the skid stage is holding a beat.
  assign en        = !skid_valid_r;
  assign in_s.ready = en;

  twc_pre #(.COORD_BITS(COORD_BITS)) u_pre (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_s.valid),
    .coord_i (in_s.coord_in),
    .mode    (wrap_mode_r),
    .org     (origin_r),
    .w       (w_eff),
    .valid_o (dv_valid[0]),
    .dvd_o   (dv_dvd[0]),
    .res_o   (dv_res[0]),
    .flags_o (dv_flags[0])
  );

  assign dv_rem[0] = '0;

  // One quotient bit per stage, most significant first.
  for (genvar i = 0; i < COORD_BITS; i++) begin : g_div
    twc_div_stage #(.COORD_BITS(COORD_BITS)) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .w       (w_eff),
      .valid_i (dv_valid[i]),
      .rem_i   (dv_rem[i]),
      .dvd_i   (dv_dvd[i]),
      .res_i   (dv_res[i]),
      .flags_i (dv_flags[i]),
      .valid_o (dv_valid[i+1]),
      .rem_o   (dv_rem[i+1]),
      .dvd_o   (dv_dvd[i+1]),
      .q_o     (dv_q[i+1]),
      .res_o   (dv_res[i+1]),
      .flags_o (dv_flags[i+1])
    );
  end

  // The last quotient bit is the period parity.
  twc_post #(.COORD_BITS(COORD_BITS)) u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .mode       (wrap_mode_r),
    .org        (origin_r),
    .w          (w_eff),
    .valid_i    (dv_valid[COORD_BITS]),
    .rem_i      (dv_rem[COORD_BITS]),
    .q_i        (dv_q[COORD_BITS]),
    .res_i      (dv_res[COORD_BITS]),
    .flags_i    (dv_flags[COORD_BITS]),
    .valid_o    (post_valid),
    .coord_o    (post_coord),
    .in_range_o (post_ok)
  );

  // Output register with skid: refill from skid first, park a beat if stalled.
  always_comb begin
    take           = out_valid_r && out_m.ready;
    incoming       = en && post_valid;
    out_valid_nxt  = out_valid_r;
    out_coord_nxt  = out_coord_r;
    out_ok_nxt     = out_ok_r;
    skid_valid_nxt = skid_valid_r;
    skid_coord_nxt = skid_coord_r;
    skid_ok_nxt    = skid_ok_r;
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_coord_nxt  = skid_coord_r;
        out_ok_nxt     = skid_ok_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = incoming;
        out_coord_nxt = post_coord;
        out_ok_nxt    = post_ok;
      end
    end else if (incoming) begin
      skid_valid_nxt = 1'b1;
      skid_coord_nxt = post_coord;
      skid_ok_nxt    = post_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_coord_r  <= out_coord_nxt;
    out_ok_r     <= out_ok_nxt;
    skid_coord_r <= skid_coord_nxt;
    skid_ok_r    <= skid_ok_nxt;
  end

  assign out_m.valid     = out_valid_r;
  assign out_m.coord_out = out_coord_r;
  assign out_m.in_range  = out_ok_r;

  // Skid only ever holds a beat behind a waiting output beat.
  `TWC_ASSERT_IMPL(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full with empty output")
  // Skid fills only after a stalled output beat.
  `TWC_ASSERT(a_skid_fill_cause, $rose(skid_valid_r) |-> $past(out_valid_r && !out_m.ready),
    "skid filled without a stalled output")
  // A beat arriving at a stalled output must be parked, not dropped.
  `TWC_ASSERT(a_no_drop, (out_valid_r && !out_m.ready && post_valid && en) |=> skid_valid_r,
    "beat dropped at stalled output")

endmodule

`default_nettype wire
